/* design/msq_pkg.sv */
// Package for the marching squares cell: widths, codes, records and the case table.
package msq_pkg;

    // Grid limits and fraction format.
    localparam int MAX_GRID_WIDTH  = 1024;
    localparam int MAX_GRID_HEIGHT = 1024;
    localparam int FRACTION_BITS   = 16;
    localparam int FRAC_W          = FRACTION_BITS + 1;

    // Field widths.
    localparam int COORD_W = 10;
    localparam int ALT_W   = 20;
    localparam int LEVEL_W = 19;
    localparam int GRID_W  = 11;
    localparam int EDGE_W  = 21;
    localparam int DIFF_W  = ALT_W + 2;
    localparam int MAG_W   = ALT_W + 1;
    localparam int REM_W   = MAG_W + 1;
    localparam int PROD_W  = COORD_W + GRID_W;

    // Divider pipeline shape.
    localparam int DIV_STEPS  = 3;
    localparam int DIV_STAGES = (FRAC_W + DIV_STEPS - 1) / DIV_STEPS;

    // Configuration port.
    localparam int CFG_AW = 4;
    typedef enum logic [1:0] {
        REG_CONTOUR_LEVEL = 2'd0,
        REG_MAX_ALTITUDE  = 2'd1,
        REG_GRID_WIDTH    = 2'd2,
        REG_GRID_HEIGHT   = 2'd3
    } t_reg_idx;

    // Cell sides.
    typedef enum logic [1:0] {
        SIDE_TOP    = 2'd0,
        SIDE_RIGHT  = 2'd1,
        SIDE_BOTTOM = 2'd2,
        SIDE_LEFT   = 2'd3
    } t_side;

    // Special case codes.
    localparam logic [3:0] CASE_EMPTY   = 4'd0;
    localparam logic [3:0] CASE_FULL    = 4'd15;
    localparam logic [3:0] CASE_SADDLE5 = 4'd5;
    localparam logic [3:0] CASE_SADDLE10 = 4'd10;

    // Segment plan of one case.
    typedef struct packed {
        logic [1:0] nseg;
        t_side      a0;
        t_side      b0;
        t_side      a1;
        t_side      b1;
    } t_seg_plan;

    // Per-item record that travels beside the dividers.
    typedef struct packed {
        logic [3:0]                   code;
        logic [1:0]                   segv;
        t_side                        a0;
        t_side                        b0;
        t_side                        a1;
        t_side                        b1;
        logic [3:0][EDGE_W-1:0]       ids;
    } t_meta;

    // Segment table for every case; empty and full give no segment.
    function automatic t_seg_plan seg_plan(input logic [3:0] code);
        t_seg_plan p;
        p = '{nseg: 2'd1, a0: SIDE_TOP, b0: SIDE_TOP, a1: SIDE_TOP, b1: SIDE_TOP};
        unique case (code)
            4'd1:  begin p.a0 = SIDE_LEFT;   p.b0 = SIDE_TOP;    end
            4'd2:  begin p.a0 = SIDE_TOP;    p.b0 = SIDE_RIGHT;  end
            4'd3:  begin p.a0 = SIDE_LEFT;   p.b0 = SIDE_RIGHT;  end
            4'd4:  begin p.a0 = SIDE_RIGHT;  p.b0 = SIDE_BOTTOM; end
            4'd5:  begin p.nseg = 2'd2; p.a0 = SIDE_LEFT; p.b0 = SIDE_TOP;
                         p.a1 = SIDE_RIGHT; p.b1 = SIDE_BOTTOM; end
            4'd6:  begin p.a0 = SIDE_TOP;    p.b0 = SIDE_BOTTOM; end
            4'd7:  begin p.a0 = SIDE_LEFT;   p.b0 = SIDE_BOTTOM; end
            4'd8:  begin p.a0 = SIDE_BOTTOM; p.b0 = SIDE_LEFT;   end
            4'd9:  begin p.a0 = SIDE_BOTTOM; p.b0 = SIDE_TOP;    end
            4'd10: begin p.nseg = 2'd2; p.a0 = SIDE_TOP; p.b0 = SIDE_RIGHT;
                         p.a1 = SIDE_BOTTOM; p.b1 = SIDE_LEFT; end
            4'd11: begin p.a0 = SIDE_BOTTOM; p.b0 = SIDE_RIGHT;  end
            4'd12: begin p.a0 = SIDE_RIGHT;  p.b0 = SIDE_LEFT;   end
            4'd13: begin p.a0 = SIDE_RIGHT;  p.b0 = SIDE_TOP;    end
            4'd14: begin p.a0 = SIDE_TOP;    p.b0 = SIDE_LEFT;   end
            default: p.nseg = 2'd0;
        endcase
        return p;
    endfunction

endpackage

/* design/msq_if.sv */
// Channel interfaces: cell items in, contour segments out.
interface msq_cell_if;
    import msq_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [COORD_W-1:0]        cell_x;
    logic [COORD_W-1:0]        cell_y;
    logic signed [ALT_W-1:0]   alt_top_left;
    logic signed [ALT_W-1:0]   alt_top_right;
    logic signed [ALT_W-1:0]   alt_bottom_right;
    logic signed [ALT_W-1:0]   alt_bottom_left;
    logic [3:0]                ground_mask;
    logic [3:0]                reached_mask;

    modport source (output valid, cell_x, cell_y, alt_top_left, alt_top_right,
                    alt_bottom_right, alt_bottom_left, ground_mask, reached_mask,
                    input ready);
    modport sink   (input valid, cell_x, cell_y, alt_top_left, alt_top_right,
                    alt_bottom_right, alt_bottom_left, ground_mask, reached_mask,
                    output ready);
endinterface

interface msq_seg_if;
    import msq_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [3:0]           case_code;
    logic [1:0]           start_side;
    logic [1:0]           end_side;
    logic [EDGE_W-1:0]    start_edge_id;
    logic [EDGE_W-1:0]    end_edge_id;
    logic [FRAC_W-1:0]    start_fraction;
    logic [FRAC_W-1:0]    end_fraction;
    logic                 last_segment;

    modport source (output valid, case_code, start_side, end_side, start_edge_id,
                    end_edge_id, start_fraction, end_fraction, last_segment,
                    input ready);
    modport sink   (input valid, case_code, start_side, end_side, start_edge_id,
                    end_edge_id, start_fraction, end_fraction, last_segment,
                    output ready);
endinterface

/* design/marching_squares_cell_top.sv */
// Top level of the marching squares cell: config registers, case logic, pipeline, output.
//
//  channel   | dir | form       | carries
//  ----------+-----+------------+------------------------------------------
//  i_cell    | in  | valid/ready| one grid cell: position, altitudes, masks
//  o_seg     | out | valid/ready| one contour segment per transfer
//  APB       | in  | psel..     | contour_level, max_altitude, grid size
//
// A cell enters every cycle while o_seg accepts; the first segment leaves after stage 1,
// stage 2 and the divider stages. A cell with two segments holds the output stage until
// both have left, so saddle cells stall the input; that limit is set by the output port.
// Reset clears the configuration to its defaults and all stage valid bits.
// A stall on o_seg freezes every stage at once; nothing is dropped or repeated.
module marching_squares_cell_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    msq_cell_if.sink                      i_cell,
    msq_seg_if.source                     o_seg,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msq_pkg::CFG_AW-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import msq_pkg::*;

    // Configuration registers.
    logic [LEVEL_W-1:0] r_level, r_max;
    logic [GRID_W-1:0]  r_gw, r_gh;
    t_reg_idx           cfg_idx;

    assign cfg_idx = t_reg_idx'(paddr[3:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_max   <= '1;
            r_gw    <= GRID_W'(MAX_GRID_WIDTH);
            r_gh    <= GRID_W'(MAX_GRID_HEIGHT);
        end else if (psel && penable && pwrite) begin
            unique case (cfg_idx)
                REG_CONTOUR_LEVEL: r_level <= pwdata[LEVEL_W-1:0];
                REG_MAX_ALTITUDE:  r_max   <= pwdata[LEVEL_W-1:0];
                REG_GRID_WIDTH:    r_gw    <= pwdata[GRID_W-1:0];
                REG_GRID_HEIGHT:   r_gh    <= pwdata[GRID_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (cfg_idx)
            REG_CONTOUR_LEVEL: prdata = 32'(r_level);
            REG_MAX_ALTITUDE:  prdata = 32'(r_max);
            REG_GRID_WIDTH:    prdata = 32'(r_gw);
            REG_GRID_HEIGHT:   prdata = 32'(r_gh);
            default:           prdata = '0;
        endcase
    end

    // Clamped grid size.
    logic [GRID_W-1:0] wc, hc, wm1;
    always_comb begin
        if (r_gw < GRID_W'(2))                   wc = GRID_W'(2);
        else if (r_gw > GRID_W'(MAX_GRID_WIDTH)) wc = GRID_W'(MAX_GRID_WIDTH);
        else                                     wc = r_gw;
        if (r_gh < GRID_W'(2))                    hc = GRID_W'(2);
        else if (r_gh > GRID_W'(MAX_GRID_HEIGHT)) hc = GRID_W'(MAX_GRID_HEIGHT);
        else                                      hc = r_gh;
        wm1 = wc - GRID_W'(1);
    end

    // Global pipeline enable, driven by the output stage.
    logic en;
    assign i_cell.ready = en;

    // Stage 1: classification, differences, sum and products.
    logic signed [ALT_W-1:0]  z [4];
    logic signed [DIFF_W-1:0] lvl_s, max_s;
    logic                     s1_void, s1_high;
    logic [3:0]               s1_code;
    logic signed [DIFF_W-1:0] s1_num [4], s1_den [4];
    logic signed [DIFF_W-1:0] sum4;

    assign z[0] = i_cell.alt_top_left;
    assign z[1] = i_cell.alt_top_right;
    assign z[2] = i_cell.alt_bottom_right;
    assign z[3] = i_cell.alt_bottom_left;
    assign lvl_s = DIFF_W'({1'b0, r_level});
    assign max_s = DIFF_W'({1'b0, r_max});

    always_comb begin
        s1_void = (i_cell.ground_mask != 4'h0) || (i_cell.reached_mask != 4'hF);
        for (int c = 0; c < 4; c++) begin
            if (DIFF_W'(z[c]) >= max_s) s1_void = 1'b1;
            s1_code[c] = DIFF_W'(z[c]) >= lvl_s;
            s1_num[c]  = lvl_s - DIFF_W'(z[c]);
            s1_den[c]  = DIFF_W'(z[(c+1)%4]) - DIFF_W'(z[c]);
        end
        sum4 = (DIFF_W'(z[0]) + DIFF_W'(z[1])) + (DIFF_W'(z[2]) + DIFF_W'(z[3]));
        s1_high = sum4 >= $signed({1'b0, r_level, 2'b00});
    end

    logic                     r1_v, r1_void, r1_high;
    logic [3:0]               r1_code;
    logic signed [DIFF_W-1:0] r1_num [4], r1_den [4];
    logic [COORD_W-1:0]       r1_x;
    logic [PROD_W-1:0]        r1_ptop, r1_pyw, r1_nh;
    logic [GRID_W-1:0]        r1_wm1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r1_v <= 1'b0;
        else if (en)   r1_v <= i_cell.valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_void <= s1_void;
            r1_high <= s1_high;
            r1_code <= s1_code;
            r1_num  <= s1_num;
            r1_den  <= s1_den;
            r1_x    <= i_cell.cell_x;
            r1_ptop <= PROD_W'(i_cell.cell_y * wm1);
            r1_pyw  <= PROD_W'(i_cell.cell_y * wc);
            r1_nh   <= PROD_W'(wm1 * hc);
            r1_wm1  <= wm1;
        end
    end

    // Stage 2: endpoint checks, magnitudes, edge ids and segment plan.
    logic [MAG_W-1:0]  s2_n [4], s2_d [4];
    logic [3:0]        s2_ok;
    logic [EDGE_W:0]   id_top, id_left;
    t_seg_plan         plan;
    t_meta             s2_meta;
    logic              join_tr;

    always_comb begin
        logic signed [DIFF_W-1:0] nn, dd;
        for (int c = 0; c < 4; c++) begin
            if (r1_den[c] < 0) begin
                nn = -r1_num[c];
                dd = -r1_den[c];
            end else begin
                nn = r1_num[c];
                dd = r1_den[c];
            end
            s2_ok[c] = (r1_den[c] != '0) && (nn >= 0) && (nn <= dd);
            s2_n[c]  = MAG_W'(nn);
            s2_d[c]  = MAG_W'(dd);
        end

        id_top  = (EDGE_W+1)'(r1_ptop) + (EDGE_W+1)'(r1_x);
        id_left = (EDGE_W+1)'(r1_nh) + (EDGE_W+1)'(r1_pyw) + (EDGE_W+1)'(r1_x);

        plan    = seg_plan(r1_code);
        join_tr = (r1_code == CASE_SADDLE5) ? r1_high : !r1_high;
        if (r1_code == CASE_SADDLE5 || r1_code == CASE_SADDLE10) begin
            if (join_tr) begin
                plan.a0 = SIDE_TOP;    plan.b0 = SIDE_RIGHT;
                plan.a1 = SIDE_BOTTOM; plan.b1 = SIDE_LEFT;
            end else begin
                plan.a0 = SIDE_LEFT;   plan.b0 = SIDE_TOP;
                plan.a1 = SIDE_RIGHT;  plan.b1 = SIDE_BOTTOM;
            end
        end

        s2_meta.code    = r1_code;
        s2_meta.a0      = plan.a0;
        s2_meta.b0      = plan.b0;
        s2_meta.a1      = plan.a1;
        s2_meta.b1      = plan.b1;
        s2_meta.segv[0] = !r1_void && (plan.nseg >= 2'd1) && s2_ok[plan.a0] && s2_ok[plan.b0];
        s2_meta.segv[1] = !r1_void && (plan.nseg == 2'd2) && s2_ok[plan.a1] && s2_ok[plan.b1];
        s2_meta.ids[SIDE_TOP]    = id_top[EDGE_W-1:0];
        s2_meta.ids[SIDE_BOTTOM] = EDGE_W'(id_top + (EDGE_W+1)'(r1_wm1));
        s2_meta.ids[SIDE_LEFT]   = id_left[EDGE_W-1:0];
        s2_meta.ids[SIDE_RIGHT]  = EDGE_W'(id_left + (EDGE_W+1)'(1));
    end

    logic             r2_v;
    t_meta            r2_meta;
    logic [MAG_W-1:0] r2_n [4], r2_d [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r2_v <= 1'b0;
        else if (en)   r2_v <= r1_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_meta <= s2_meta;
            r2_n    <= s2_n;
            r2_d    <= s2_d;
        end
    end

    // Divider stages: one lane per cell side.
    logic [FRAC_W-1:0] quot [4];
    for (genvar g = 0; g < 4; g++) begin : g_div
        msq_div u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  (r2_n[g]),
            .i_den  (r2_d[g]),
            .o_quot (quot[g])
        );
    end

    // Records travel beside the dividers.
    logic  r_mv [DIV_STAGES];
    t_meta r_m  [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int st = 0; st < DIV_STAGES; st++) r_mv[st] <= 1'b0;
        end else if (en) begin
            r_mv[0] <= r2_v;
            for (int st = 1; st < DIV_STAGES; st++) r_mv[st] <= r_mv[st-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m[0] <= r2_meta;
            for (int st = 1; st < DIV_STAGES; st++) r_m[st] <= r_m[st-1];
        end
    end

    // Output stage: up to two segments leave in order.
    t_meta fin;
    logic  r_first_done;
    logic  seg0_pend, seg1_pend, sel1, is_last;
    t_side sa, sb;

    assign fin       = r_m[DIV_STAGES-1];
    assign seg0_pend = fin.segv[0] && !r_first_done;
    assign seg1_pend = fin.segv[1];
    assign sel1      = !seg0_pend;
    assign is_last   = sel1 || !seg1_pend;
    assign sa        = sel1 ? fin.a1 : fin.a0;
    assign sb        = sel1 ? fin.b1 : fin.b0;

    assign o_seg.valid          = r_mv[DIV_STAGES-1] && (seg0_pend || seg1_pend);
    assign o_seg.case_code      = fin.code;
    assign o_seg.start_side     = sa;
    assign o_seg.end_side       = sb;
    assign o_seg.start_edge_id  = fin.ids[sa];
    assign o_seg.end_edge_id    = fin.ids[sb];
    assign o_seg.start_fraction = quot[sa];
    assign o_seg.end_fraction   = quot[sb];
    assign o_seg.last_segment   = is_last;

    assign en = !o_seg.valid || (o_seg.ready && is_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)                        r_first_done <= 1'b0;
        else if (en)                         r_first_done <= 1'b0;
        else if (o_seg.valid && o_seg.ready) r_first_done <= 1'b1;
    end

    // Only saddle cells give a segment that is not the last one.
    a_two_only_saddle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_seg.valid && !o_seg.last_segment |->
            (o_seg.case_code == CASE_SADDLE5 || o_seg.case_code == CASE_SADDLE10))
        else $error("non-last segment outside a saddle case");

    // Input stalls only behind a pending segment.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cell.ready |-> o_seg.valid)
        else $error("input stalled with no segment waiting");

    // Empty and full cases never produce segments.
    a_no_flat_case: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_seg.valid |-> (o_seg.case_code != CASE_EMPTY && o_seg.case_code != CASE_FULL))
        else $error("segment from an empty or full cell");

    // Fractions stay within one.
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_seg.valid |-> (o_seg.start_fraction <= (FRAC_W'(1) << FRACTION_BITS)) &&
                        (o_seg.end_fraction <= (FRAC_W'(1) << FRACTION_BITS)))
        else $error("crossing fraction above one");

    // After a non-last segment transfer, the last one of the same cell follows.
    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_seg.valid && o_seg.ready && !o_seg.last_segment |=>
            o_seg.valid && o_seg.last_segment)
        else $error("second segment of a saddle cell missing");

endmodule

/* design/msq_div.sv */
// Pipelined restoring divider: rounded crossing fraction num/den in Q1.FRACTION_BITS.
module msq_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [msq_pkg::MAG_W-1:0]    i_num,
    input  logic [msq_pkg::MAG_W-1:0]    i_den,
    output logic [msq_pkg::FRAC_W-1:0]   o_quot
);
    import msq_pkg::*;

    logic [REM_W-1:0]  r_rem  [DIV_STAGES];
    logic [REM_W-1:0]  r_dvs  [DIV_STAGES];
    logic [FRAC_W-1:0] r_low  [DIV_STAGES];
    logic [FRAC_W-1:0] r_quot [DIV_STAGES];
    logic [REM_W-1:0]  n_rem  [DIV_STAGES];
    logic [REM_W-1:0]  n_dvs  [DIV_STAGES];
    logic [FRAC_W-1:0] n_low  [DIV_STAGES];
    logic [FRAC_W-1:0] n_quot [DIV_STAGES];

    // The dividend is (num << FRAC_W) + den over 2*den; its top part starts the remainder.
    always_comb begin
        logic [REM_W-1:0]  rem;
        logic [REM_W-1:0]  dvs;
        logic [FRAC_W-1:0] low;
        logic [FRAC_W-1:0] quot;
        logic [REM_W-1:0]  trial;
        int                k;
        for (int st = 0; st < DIV_STAGES; st++) begin
            if (st == 0) begin
                rem  = {1'b0, i_num} + REM_W'(i_den >> FRAC_W);
                dvs  = {i_den, 1'b0};
                low  = FRAC_W'(i_den);
                quot = '0;
            end else begin
                rem  = r_rem[st-1];
                dvs  = r_dvs[st-1];
                low  = r_low[st-1];
                quot = r_quot[st-1];
            end
            for (int j = 0; j < DIV_STEPS; j++) begin
                k = st * DIV_STEPS + j;
                if (k < FRAC_W) begin
                    trial = {rem[REM_W-2:0], low[FRAC_W-1-k]};
                    if (trial >= dvs) begin
                        rem = trial - dvs;
                        quot[FRAC_W-1-k] = 1'b1;
                    end else begin
                        rem = trial;
                    end
                end
            end
            n_rem[st]  = rem;
            n_dvs[st]  = dvs;
            n_low[st]  = low;
            n_quot[st] = quot;
        end
    end

    // Stage registers advance together with the rest of the pipeline.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_dvs  <= n_dvs;
            r_low  <= n_low;
            r_quot <= n_quot;
        end
    end

    assign o_quot = r_quot[DIV_STAGES-1];

endmodule
